@@ rtl/core/pes_pkg.sv @@
// Package: shared types, phase codes and helpers of the PES header parser.
package pes_pkg;

    typedef enum logic [4:0] {
        PH_PREFIX, PH_SID, PH_LENHI, PH_LENLO, PH_FLAG1, PH_FLAG2, PH_HDRLEN,
        PH_PTS, PH_ESCR, PH_RATE, PH_TRICK, PH_COPY, PH_CRC, PH_EXT, PH_PRIV,
        PH_PACKLEN, PH_PACKSKIP, PH_SEQ, PH_PSTD, PH_EXT2LEN, PH_EXT2SKIP,
        PH_FINISH, PH_STUFF, PH_DONE, PH_ERROR
    } phase_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
    localparam logic [1:0] ST_OVERRUN    = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE = 2'd3;

    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } pes_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  stream_kind;
        logic [15:0] packet_length;
        logic [8:0]  header_size;
        logic [32:0] pts_value;
        logic [32:0] dts_value;
        logic [32:0] escr_value;
        logic [21:0] es_rate_value;
        logic [15:0] header_flag_bytes;
        logic [7:0]  trick_mode_byte;
        logic [15:0] previous_crc;
        logic [33:0] extension_fields;
    } pes_out_t;

    function automatic logic has_optional(input logic [7:0] sid);
        return !(sid == 8'hBC || sid == 8'hBE || sid == 8'hBF || sid == 8'hF0 ||
                 sid == 8'hF1 || sid == 8'hF2 || sid == 8'hF8 || sid == 8'hFF);
    endfunction

    function automatic logic [32:0] time_stamp(input logic [39:0] a);
        return {a[35:33], a[31:17], a[15:1]};
    endfunction

endpackage

@@ rtl/core/pes_byte_queue.sv @@
// Module: short request queue between the accepting front and the parsing back.
module pes_byte_queue
    import pes_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  pes_in_t s_data,
    output logic    q_valid,
    input  logic    q_ready,
    output pes_in_t q_data
);
    pes_in_t    mem_reg [QueueDepth];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign s_ready = (count_reg != 2'(QueueDepth));
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn) count_reg <= 2'(QueueDepth);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_count_track;
        @(posedge aclk) disable iff (!aresetn)
            (push && !pop) |=> count_reg == $past(count_reg) + 2'd1;
    endproperty
    a_count_track: assert property (p_count_track) else $error("queue count slip");

    property p_empty_no_valid;
        @(posedge aclk) disable iff (!aresetn) (count_reg == 2'd0) |-> !q_valid;
    endproperty
    a_empty_no_valid: assert property (p_empty_no_valid) else $error("valid when empty");
endmodule

@@ rtl/core/pes_parse_core.sv @@
// Module: byte-per-cycle PES header parsing engine with registered result, while the result register is free.
module pes_parse_core
    import pes_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  pes_in_t  q_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pes_out_t m_data
);
    phase_t      phase_reg, phase_next;
    logic [16:0] seen_reg, seen_next;
    logic [7:0]  skip_reg, skip_next;
    logic [7:0]  hdl_reg, hdl_next;
    logic [8:0]  oc_reg, oc_next;
    logic [1:0]  err_reg, err_next;
    logic [7:0]  sid_reg, sid_next;
    logic [15:0] plen_reg, plen_next;
    logic [32:0] pts_reg, pts_next, dts_reg, dts_next, escr_reg, escr_next;
    logic [21:0] rate_reg, rate_next;
    logic [15:0] flags_reg, flags_next;
    logic [7:0]  ef_reg, ef_next, trick_reg, trick_next;
    logic [15:0] crc_reg, crc_next;
    logic [33:0] ext_reg, ext_next;
    logic [47:0] asm_reg, asm_next;
    logic        out_valid_reg;
    pes_out_t    out_reg, out_next;
    logic        take;

    // Accept when the result register is free or is drained this cycle.
    assign q_ready = !out_valid_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        logic [7:0]  b;
        logic [7:0]  f2;
        logic [47:0] a;
        logic [4:0]  cand;
        logic        done;
        logic [1:0]  st;
        b = q_data.data_byte;
        // A candidate of PH_PREFIX means no field ended on this byte.
        a = '0; cand = 5'(PH_PREFIX); done = 1'b0; st = ST_OK;
        phase_next = phase_reg; seen_next = seen_reg; skip_next = skip_reg;
        hdl_next = hdl_reg; oc_next = oc_reg; err_next = err_reg; sid_next = sid_reg;
        plen_next = plen_reg; pts_next = pts_reg; dts_next = dts_reg;
        escr_next = escr_reg; rate_next = rate_reg; flags_next = flags_reg;
        ef_next = ef_reg; trick_next = trick_reg; crc_next = crc_reg;
        ext_next = ext_reg; asm_next = asm_reg;
        if (q_data.first_byte) begin
            phase_next = PH_PREFIX; seen_next = '0; skip_next = '0; hdl_next = '0;
            oc_next = '0; err_next = '0; sid_next = '0; plen_next = '0; pts_next = '0;
            dts_next = '0; escr_next = '0; rate_next = '0; flags_next = '0; ef_next = '0;
            trick_next = '0; crc_next = '0; ext_next = '0; asm_next = '0;
        end
        if (seen_next != 17'h1FFFF) seen_next = seen_next + 17'd1;
        f2 = flags_next[7:0];
        unique case (phase_next) inside
            PH_PREFIX: begin
                if (b != ((seen_next == 17'd3) ? 8'd1 : 8'd0)) err_next = ST_BAD_PREFIX;
                if (seen_next >= 17'd3)
                    phase_next = (err_next != ST_OK) ? PH_ERROR : PH_SID;
            end
            PH_SID:   begin sid_next = b; phase_next = PH_LENHI; end
            PH_LENHI: begin plen_next = {b, 8'h00}; phase_next = PH_LENLO; end
            PH_LENLO: begin
                plen_next = {plen_next[15:8], b};
                phase_next = has_optional(sid_next) ? PH_FLAG1 : PH_DONE;
            end
            PH_FLAG1: begin flags_next = {b, 8'h00}; phase_next = PH_FLAG2; end
            PH_FLAG2: begin flags_next = {flags_next[15:8], b}; phase_next = PH_HDRLEN; end
            PH_HDRLEN: begin
                hdl_next = b; oc_next = '0; cand = 5'(PH_PTS);
            end
            PH_STUFF: begin
                if (skip_next != 8'd0) skip_next = skip_next - 8'd1;
                if (skip_next == 8'd0) phase_next = PH_DONE;
            end
            PH_DONE, PH_ERROR: ;
            default: begin
                if (oc_next != 9'd511) oc_next = oc_next + 9'd1;
                asm_next = {asm_next[39:0], b};
                a = asm_next;
                if (skip_next != 8'd0) skip_next = skip_next - 8'd1;
                unique case (phase_next)
                    PH_PTS: begin
                        if (skip_next == 8'd5 && flags_next[7:6] == 2'b11) begin
                            pts_next = time_stamp(a[39:0]); asm_next = '0;
                        end else if (skip_next == 8'd0) begin
                            if (flags_next[7:6] == 2'b11) dts_next = time_stamp(a[39:0]);
                            else begin
                                pts_next = time_stamp(a[39:0]); dts_next = pts_next;
                            end
                            cand = 5'(PH_ESCR);
                        end
                    end
                    PH_ESCR: if (skip_next == 8'd0) begin
                        escr_next = {a[45:43], a[41:40], a[39:32], a[31:27], a[25:24],
                                     a[23:16], a[15:11]};
                        cand = 5'(PH_RATE);
                    end
                    PH_RATE: if (skip_next == 8'd0) begin
                        rate_next = {a[22:16], a[15:8], a[7:1]};
                        cand = 5'(PH_TRICK);
                    end
                    PH_TRICK: begin trick_next = b; cand = 5'(PH_COPY); end
                    PH_COPY: begin ext_next[33:28] = ext_next[33:28] | b[5:0];
                        cand = 5'(PH_CRC); end
                    PH_CRC: if (skip_next == 8'd0) begin
                        crc_next = a[15:0]; cand = 5'(PH_EXT);
                    end
                    PH_EXT: begin ef_next = b; cand = 5'(PH_PRIV); end
                    PH_PRIV: if (skip_next == 8'd0) cand = 5'(PH_PACKLEN);
                    PH_PACKLEN: begin
                        if (b == 8'd0) cand = 5'(PH_SEQ);
                        else begin phase_next = PH_PACKSKIP; skip_next = b; asm_next = '0; end
                    end
                    PH_PACKSKIP: if (skip_next == 8'd0) cand = 5'(PH_SEQ);
                    PH_SEQ: if (skip_next == 8'd0) begin
                        ext_next[27:14] = ext_next[27:14] | {a[14:8], a[6], a[5:0]};
                        cand = 5'(PH_PSTD);
                    end
                    PH_PSTD: if (skip_next == 8'd0) begin
                        ext_next[13:0] = ext_next[13:0] | a[13:0];
                        cand = 5'(PH_EXT2LEN);
                    end
                    PH_EXT2LEN: begin
                        if (b == 8'd0) cand = 5'(PH_FINISH);
                        else begin phase_next = PH_EXT2SKIP; skip_next = b; asm_next = '0; end
                    end
                    PH_EXT2SKIP: if (skip_next == 8'd0) cand = 5'(PH_FINISH);
                    default: ;
                endcase
            end
        endcase
        // Advance to the first enabled field at or after the candidate, or close the header.
        if (cand != 5'(PH_PREFIX)) begin
            done = 1'b0;
            if (cand == 5'(PH_PTS)) begin
                if (f2[7]) begin phase_next = PH_PTS;
                    skip_next = f2[6] ? 8'd10 : 8'd5; done = 1'b1; end
                else cand = 5'(PH_ESCR);
            end
            if (!done && cand == 5'(PH_ESCR)) begin
                if (f2[5]) begin phase_next = PH_ESCR; skip_next = 8'd6; done = 1'b1; end
                else cand = 5'(PH_RATE);
            end
            if (!done && cand == 5'(PH_RATE)) begin
                if (f2[4]) begin phase_next = PH_RATE; skip_next = 8'd3; done = 1'b1; end
                else cand = 5'(PH_TRICK);
            end
            if (!done && cand == 5'(PH_TRICK)) begin
                if (f2[3]) begin phase_next = PH_TRICK; skip_next = 8'd1; done = 1'b1; end
                else cand = 5'(PH_COPY);
            end
            if (!done && cand == 5'(PH_COPY)) begin
                if (f2[2]) begin phase_next = PH_COPY; skip_next = 8'd1; done = 1'b1; end
                else cand = 5'(PH_CRC);
            end
            if (!done && cand == 5'(PH_CRC)) begin
                if (f2[1]) begin phase_next = PH_CRC; skip_next = 8'd2; done = 1'b1; end
                else cand = 5'(PH_EXT);
            end
            if (!done && cand == 5'(PH_EXT)) begin
                if (f2[0]) begin phase_next = PH_EXT; skip_next = 8'd1; done = 1'b1; end
                else cand = 5'(PH_FINISH);
            end
            if (!done && cand == 5'(PH_PRIV)) begin
                if (ef_next[7]) begin phase_next = PH_PRIV; skip_next = 8'd16; done = 1'b1; end
                else cand = 5'(PH_PACKLEN);
            end
            if (!done && cand == 5'(PH_PACKLEN)) begin
                if (ef_next[6]) begin phase_next = PH_PACKLEN; skip_next = 8'd1;
                    done = 1'b1; end
                else cand = 5'(PH_SEQ);
            end
            if (!done && cand == 5'(PH_SEQ)) begin
                if (ef_next[5]) begin phase_next = PH_SEQ; skip_next = 8'd2; done = 1'b1; end
                else cand = 5'(PH_PSTD);
            end
            if (!done && cand == 5'(PH_PSTD)) begin
                if (ef_next[4]) begin phase_next = PH_PSTD; skip_next = 8'd2; done = 1'b1; end
                else cand = 5'(PH_EXT2LEN);
            end
            if (!done && cand == 5'(PH_EXT2LEN)) begin
                if (ef_next[0]) begin phase_next = PH_EXT2LEN; skip_next = 8'd1;
                    done = 1'b1; end
                else cand = 5'(PH_FINISH);
            end
            if (done) asm_next = '0;
            else if (oc_next > {1'b0, hdl_next}) begin
                err_next = ST_OVERRUN; phase_next = PH_ERROR;
            end else if (oc_next == {1'b0, hdl_next}) phase_next = PH_DONE;
            else begin
                phase_next = PH_STUFF; skip_next = 8'(hdl_next - oc_next[7:0]);
                asm_next = '0;
            end
        end
        // Final status for a result on this byte.
        if (seen_next < 17'd3) st = ST_INCOMPLETE;
        else if (err_next == ST_BAD_PREFIX) st = ST_BAD_PREFIX;
        else if (seen_next < 17'd6) st = ST_INCOMPLETE;
        else if ((seen_next - 17'd6) < {1'b0, plen_next}) st = ST_INCOMPLETE;
        else if (err_next == ST_OVERRUN) st = ST_OVERRUN;
        else if (phase_next != PH_DONE) st = ST_INCOMPLETE;
        else st = ST_OK;
        out_next.status = st;
        out_next.stream_kind = sid_next;
        out_next.packet_length = plen_next;
        out_next.header_size = (st != ST_OK) ? 9'd0 :
                               (has_optional(sid_next) ? 9'd9 + {1'b0, hdl_next} : 9'd6);
        out_next.pts_value = pts_next;
        out_next.dts_value = dts_next;
        out_next.escr_value = escr_next;
        out_next.es_rate_value = rate_next;
        out_next.header_flag_bytes = flags_next;
        out_next.trick_mode_byte = trick_next;
        out_next.previous_crc = crc_next;
        out_next.extension_fields = ext_next;
    end

    always_ff @(posedge aclk) begin
        if (take && q_data.last_byte) begin
            out_reg <= out_next;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg <= PH_PREFIX; seen_reg <= '0; skip_reg <= '0; hdl_reg <= '0;
            oc_reg <= '0; err_reg <= '0; sid_reg <= '0; plen_reg <= '0; pts_reg <= '0;
            dts_reg <= '0; escr_reg <= '0; rate_reg <= '0; flags_reg <= '0; ef_reg <= '0;
            trick_reg <= '0; crc_reg <= '0; ext_reg <= '0; asm_reg <= '0;
        end else begin
            if (take) out_valid_reg <= q_data.last_byte;
            else if (m_ready) out_valid_reg <= 1'b0;
            if (take) begin
                if (q_data.last_byte) begin
                    // Clear the parse once the result is captured.
                    phase_reg <= PH_PREFIX; seen_reg <= '0; skip_reg <= '0;
                    hdl_reg <= '0; oc_reg <= '0; err_reg <= '0; sid_reg <= '0;
                    plen_reg <= '0; pts_reg <= '0; dts_reg <= '0; escr_reg <= '0;
                    rate_reg <= '0; flags_reg <= '0; ef_reg <= '0; trick_reg <= '0;
                    crc_reg <= '0; ext_reg <= '0; asm_reg <= '0;
                end else begin
                    phase_reg <= phase_next; seen_reg <= seen_next; skip_reg <= skip_next;
                    hdl_reg <= hdl_next; oc_reg <= oc_next; err_reg <= err_next;
                    sid_reg <= sid_next; plen_reg <= plen_next; pts_reg <= pts_next;
                    dts_reg <= dts_next; escr_reg <= escr_next; rate_reg <= rate_next;
                    flags_reg <= flags_next; ef_reg <= ef_next; trick_reg <= trick_next;
                    crc_reg <= crc_next; ext_reg <= ext_next; asm_reg <= asm_next;
                end
            end
        end
    end

    property p_hold_result;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_ready) |=> m_valid && $stable(out_reg);
    endproperty
    a_hold_result: assert property (p_hold_result) else $error("result dropped");

    property p_ok_has_len;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && out_reg.status == ST_OK) |-> out_reg.header_size >= 9'd6;
    endproperty
    a_ok_has_len: assert property (p_ok_has_len) else $error("bad header length");

    property p_clear_after_last;
        @(posedge aclk) disable iff (!aresetn)
            (take && q_data.last_byte) |=> seen_reg == 17'd0 && phase_reg == PH_PREFIX;
    endproperty
    a_clear_after_last: assert property (p_clear_after_last) else $error("parse not cleared");
endmodule

@@ rtl/core/pes_header_parser.sv @@
// Top level: MPEG-2 PES header parser with byte queue front and parsing back.
//
//   port group   | dir | contents
//   s_*          | in  | one byte request: data_byte, first_byte, last_byte
//   m_*          | out | one result per buffer, given on the byte marked last
//
// One byte per clock while the result register is not stalled; a result appears in the
// cycle after its last byte leaves the two-entry queue. The parse engine's next-state
// logic is combinational. Reset (aresetn low, synchronous) empties the queue and
// clears the parse. A stalled result register holds its result and back-pressures
// the queue, which keeps taking bytes until it is full.
module pes_header_parser
    import pes_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pes_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pes_out_t m_data
);
    logic    q_valid, q_ready;
    pes_in_t q_data;

    // Front: hold incoming requests while the engine is stalled.
    pes_byte_queue u_queue (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data
    );

    // Back: advance the parse one byte per cycle while not stalled and register the result.
    pes_parse_core u_core (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );
endmodule

@@ test/pes_header_parser_tb.sv @@
// Testbench for the PES header parser: directed buffers, random buffers, result checks.
`timescale 1ns / 1ps

module pes_header_parser_tb
    import pes_pkg::*;
;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    pes_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    pes_out_t m_data;

    pes_header_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Parse state of the predictor; fields at the block's widths, counters as saturating ints.
    phase_t      pp_phase;
    int unsigned pp_seen;
    logic [7:0]  pp_skip;
    logic [7:0]  pp_hdr_len;
    int unsigned pp_consumed;
    logic [1:0]  pp_err;
    logic [7:0]  pp_sid;
    logic [15:0] pp_len;
    logic [32:0] pp_pts, pp_dts, pp_escr;
    logic [21:0] pp_rate;
    logic [15:0] pp_flags;
    logic [7:0]  pp_ext_flags, pp_trick;
    logic [15:0] pp_crc;
    logic [33:0] pp_ext;
    logic [47:0] pp_shift;

    pes_out_t expected_results[$];
    int       failures = 0;
    bit       sending_done = 0;
    int       bytes_sent = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic bit carries_optional(logic [7:0] sid);
        case (sid) inside
            8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // 33-bit time stamp out of five bytes held in the low 40 bits.
    function automatic logic [32:0] stamp_of(logic [47:0] a);
        logic [32:0] t;
        t = {a[35:33], a[31:17], a[15:1]};
        return t;
    endfunction

    function automatic void parse_clear();
        pp_phase = PH_PREFIX; pp_seen = 0; pp_skip = 0; pp_hdr_len = 0;
        pp_consumed = 0; pp_err = ST_OK; pp_sid = 0; pp_len = 0;
        pp_pts = 0; pp_dts = 0; pp_escr = 0; pp_rate = 0; pp_flags = 0;
        pp_ext_flags = 0; pp_trick = 0; pp_crc = 0; pp_ext = 0; pp_shift = 0;
    endfunction

    function automatic void parse_enter(phase_t ph, int n);
        pp_phase = ph;
        pp_skip = n[7:0];
        pp_shift = 0;
    endfunction

    function automatic void fields_close();
        if (pp_consumed > pp_hdr_len) begin
            pp_err = ST_OVERRUN;
            pp_phase = PH_ERROR;
        end else if (pp_consumed == pp_hdr_len) begin
            pp_phase = PH_DONE;
        end else begin
            parse_enter(PH_STUFF, pp_hdr_len - pp_consumed);
        end
    endfunction

    // Move on to the first field the flags enable, starting at c.
    function automatic void parse_advance(phase_t c);
        logic [7:0] f2;
        logic [7:0] ef;
        bit         more;
        f2 = pp_flags[7:0];
        ef = pp_ext_flags;
        more = 1;
        while (more) begin
            more = 0;
            case (c)
                PH_PTS: if (f2[7:6] >= 2) parse_enter(PH_PTS, f2[7:6] == 3 ? 10 : 5);
                        else begin c = PH_ESCR; more = 1; end
                PH_ESCR: if (f2[5]) parse_enter(PH_ESCR, 6);
                         else begin c = PH_RATE; more = 1; end
                PH_RATE: if (f2[4]) parse_enter(PH_RATE, 3);
                         else begin c = PH_TRICK; more = 1; end
                PH_TRICK: if (f2[3]) parse_enter(PH_TRICK, 1);
                          else begin c = PH_COPY; more = 1; end
                PH_COPY: if (f2[2]) parse_enter(PH_COPY, 1);
                         else begin c = PH_CRC; more = 1; end
                PH_CRC: if (f2[1]) parse_enter(PH_CRC, 2);
                        else begin c = PH_EXT; more = 1; end
                PH_EXT: if (f2[0]) parse_enter(PH_EXT, 1);
                        else begin c = PH_FINISH; more = 1; end
                PH_PRIV: if (ef[7]) parse_enter(PH_PRIV, 16);
                         else begin c = PH_PACKLEN; more = 1; end
                PH_PACKLEN: if (ef[6]) parse_enter(PH_PACKLEN, 1);
                            else begin c = PH_SEQ; more = 1; end
                PH_SEQ: if (ef[5]) parse_enter(PH_SEQ, 2);
                        else begin c = PH_PSTD; more = 1; end
                PH_PSTD: if (ef[4]) parse_enter(PH_PSTD, 2);
                         else begin c = PH_EXT2LEN; more = 1; end
                PH_EXT2LEN: if (ef[0]) parse_enter(PH_EXT2LEN, 1);
                            else begin c = PH_FINISH; more = 1; end
                default: fields_close();
            endcase
        end
    endfunction

    // One byte inside the optional fields.
    function automatic void optional_byte(logic [7:0] b);
        logic [47:0] a;
        if (pp_consumed < 511) pp_consumed++;
        pp_shift = {pp_shift[39:0], b};
        a = pp_shift;
        if (pp_skip > 0) pp_skip--;
        case (pp_phase)
            PH_PTS: begin
                if (pp_skip == 5 && pp_flags[7:6] == 2'd3) begin
                    pp_pts = stamp_of(a);
                    pp_shift = 0;
                end else if (pp_skip == 0) begin
                    if (pp_flags[7:6] == 2'd3) pp_dts = stamp_of(a);
                    else begin pp_pts = stamp_of(a); pp_dts = pp_pts; end
                    parse_advance(PH_ESCR);
                end
            end
            PH_ESCR: if (pp_skip == 0) begin
                pp_escr = {a[45:43], a[41:40], a[39:32], a[31:27], a[25:24],
                           a[23:16], a[15:11]};
                parse_advance(PH_RATE);
            end
            PH_RATE: if (pp_skip == 0) begin
                pp_rate = {a[22:16], a[15:8], a[7:1]};
                parse_advance(PH_TRICK);
            end
            PH_TRICK: begin pp_trick = b; parse_advance(PH_COPY); end
            PH_COPY: begin pp_ext[33:28] = pp_ext[33:28] | b[5:0]; parse_advance(PH_CRC); end
            PH_CRC: if (pp_skip == 0) begin pp_crc = a[15:0]; parse_advance(PH_EXT); end
            PH_EXT: begin pp_ext_flags = b; parse_advance(PH_PRIV); end
            PH_PRIV: if (pp_skip == 0) parse_advance(PH_PACKLEN);
            PH_PACKLEN: if (b == 0) parse_advance(PH_SEQ); else parse_enter(PH_PACKSKIP, b);
            PH_PACKSKIP: if (pp_skip == 0) parse_advance(PH_SEQ);
            PH_SEQ: if (pp_skip == 0) begin
                pp_ext[27:21] = pp_ext[27:21] | a[14:8];
                pp_ext[20]    = pp_ext[20] | a[6];
                pp_ext[19:14] = pp_ext[19:14] | a[5:0];
                parse_advance(PH_PSTD);
            end
            PH_PSTD: if (pp_skip == 0) begin
                pp_ext[13:0] = pp_ext[13:0] | a[13:0];
                parse_advance(PH_EXT2LEN);
            end
            PH_EXT2LEN: if (b == 0) parse_advance(PH_FINISH); else parse_enter(PH_EXT2SKIP, b);
            PH_EXT2SKIP: if (pp_skip == 0) parse_advance(PH_FINISH);
            default: ;
        endcase
    endfunction

    function automatic logic [1:0] parse_status();
        if (pp_seen < 3) return ST_INCOMPLETE;
        if (pp_err == ST_BAD_PREFIX) return ST_BAD_PREFIX;
        if (pp_seen < 6) return ST_INCOMPLETE;
        if (pp_seen - 6 < pp_len) return ST_INCOMPLETE;
        if (pp_err == ST_OVERRUN) return ST_OVERRUN;
        if (pp_phase != PH_DONE) return ST_INCOMPLETE;
        return ST_OK;
    endfunction

    // Step the predictor by one accepted byte; return 1 with the result on a last mark.
    function automatic bit parse_byte(pes_in_t it, output pes_out_t r);
        logic [7:0] b;
        b = it.data_byte;
        r = '0;
        if (it.first_byte) parse_clear();
        if (pp_seen < 131071) pp_seen++;
        case (pp_phase) inside
            PH_PREFIX: begin
                if (b != ((pp_seen == 3) ? 8'd1 : 8'd0)) pp_err = ST_BAD_PREFIX;
                if (pp_seen >= 3) pp_phase = (pp_err != ST_OK) ? PH_ERROR : PH_SID;
            end
            PH_SID: begin pp_sid = b; pp_phase = PH_LENHI; end
            PH_LENHI: begin pp_len = {b, 8'h00}; pp_phase = PH_LENLO; end
            PH_LENLO: begin
                pp_len[7:0] = b;
                pp_phase = carries_optional(pp_sid) ? PH_FLAG1 : PH_DONE;
            end
            PH_FLAG1: begin pp_flags = {b, 8'h00}; pp_phase = PH_FLAG2; end
            PH_FLAG2: begin pp_flags[7:0] = b; pp_phase = PH_HDRLEN; end
            PH_HDRLEN: begin
                pp_hdr_len = b;
                pp_consumed = 0;
                parse_advance(PH_PTS);
            end
            PH_STUFF: begin
                if (pp_skip > 0) pp_skip--;
                if (pp_skip == 0) pp_phase = PH_DONE;
            end
            PH_DONE, PH_ERROR: ;
            default: optional_byte(b);
        endcase
        if (!it.last_byte) return 0;
        r.status = parse_status();
        r.stream_kind = pp_sid;
        r.packet_length = pp_len;
        r.header_size = (r.status != ST_OK) ? 9'd0 :
                        (carries_optional(pp_sid) ? 9'd9 + {1'b0, pp_hdr_len} : 9'd6);
        r.pts_value = pp_pts;
        r.dts_value = pp_dts;
        r.escr_value = pp_escr;
        r.es_rate_value = pp_rate;
        r.header_flag_bytes = pp_flags;
        r.trick_mode_byte = pp_trick;
        r.previous_crc = pp_crc;
        r.extension_fields = pp_ext;
        parse_clear();
        return 1;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 87) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request, hold it until taken, then feed the predictor.
    bit calm = 0;
    task automatic send_request(pes_in_t it, logic has_status, logic [1:0] typed_status);
        pes_out_t r;
        int       gap;
        gap = calm ? 0 : idle_cycles();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (parse_byte(it, r)) begin
            if (has_status && r.status != typed_status) begin
                $display("%0t: directed status expected %0d, predicted %0d",
                         $time, typed_status, r.status);
                failures++;
            end
            expected_results.push_back(r);
        end
    endtask

    task automatic release_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Build one buffer: mostly well formed, at times truncated, overrun or with a bad prefix.
    task automatic send_buffer();
        logic [7:0] buf_q[$];
        logic [7:0] body[$];
        logic [7:0] sid, f2, ef, hdr_len;
        logic [7:0] list_ids[8];
        int         pl, need, n, cut, k;
        pes_in_t    it;
        list_ids = '{8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF};
        buf_q = '{8'h00, 8'h00, 8'h01};
        if ($urandom_range(0, 19) == 0) begin
            k = $urandom_range(0, 2);
            buf_q[k] = buf_q[k] ^ 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 3) == 0) begin
            sid = list_ids[$urandom_range(0, 7)];
        end else begin
            do sid = rand_byte(); while (!carries_optional(sid));
        end
        pl = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 30);
        buf_q.push_back(sid);
        buf_q.push_back(pl[15:8]);
        buf_q.push_back(pl[7:0]);
        if (carries_optional(sid)) begin
            f2 = rand_byte();
            ef = rand_byte();
            if (f2[7:6] == 2) repeat (5) body.push_back(rand_byte());
            if (f2[7:6] == 3) repeat (10) body.push_back(rand_byte());
            if (f2[5]) repeat (6) body.push_back(rand_byte());
            if (f2[4]) repeat (3) body.push_back(rand_byte());
            if (f2[3]) body.push_back(rand_byte());
            if (f2[2]) body.push_back(rand_byte());
            if (f2[1]) repeat (2) body.push_back(rand_byte());
            if (f2[0]) begin
                body.push_back(ef);
                if (ef[7]) repeat (16) body.push_back(rand_byte());
                if (ef[6]) begin
                    n = $urandom_range(0, 3);
                    body.push_back(8'(n));
                    repeat (n) body.push_back(rand_byte());
                end
                if (ef[5]) repeat (2) body.push_back(rand_byte());
                if (ef[4]) repeat (2) body.push_back(rand_byte());
                if (ef[0]) begin
                    n = $urandom_range(0, 3);
                    body.push_back(8'(n));
                    repeat (n) body.push_back(rand_byte());
                end
            end
            need = body.size();
            k = $urandom_range(0, 39);
            if (k == 0) hdr_len = 8'hFF;
            else if (k < 4 && need > 0) hdr_len = 8'($urandom_range(0, need - 1));
            else hdr_len = 8'(need + $urandom_range(0, 4));
            buf_q.push_back(rand_byte());
            buf_q.push_back(f2);
            buf_q.push_back(hdr_len);
            foreach (body[i]) buf_q.push_back(body[i]);
            for (int i = need; i < hdr_len; i++) buf_q.push_back(rand_byte());
        end
        // Payload up to the packet length, unless it is far too long to send.
        if (pl <= 300)
            while (buf_q.size() - 6 < pl) buf_q.push_back(rand_byte());
        repeat ($urandom_range(0, 2)) buf_q.push_back(rand_byte());
        if ($urandom_range(0, 11) == 0) begin
            cut = $urandom_range(1, buf_q.size());
            while (buf_q.size() > cut) void'(buf_q.pop_back());
        end
        calm = ($urandom_range(0, 7) == 0);
        foreach (buf_q[i]) begin
            it.data_byte = buf_q[i];
            it.first_byte = (i == 0);
            it.last_byte = (i == buf_q.size() - 1);
            send_request(it, 1'b0, ST_OK);
        end
    endtask

    // Directed buffers: one lone byte, a bad prefix, a padding stream with no optional
    // header, and a PTS-only header that overruns a zero header length.
    typedef struct {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       has_status;
        logic [1:0] status;
    } directed_row_t;

    directed_row_t directed_rows[] = '{
        '{8'h00, 1, 1, 1, ST_INCOMPLETE},
        '{8'h00, 1, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h02, 0, 1, 1, ST_BAD_PREFIX},
        '{8'h00, 1, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h01, 0, 0, 0, ST_OK},
        '{8'hBE, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h00, 0, 1, 1, ST_OK},
        '{8'h00, 1, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h01, 0, 0, 0, ST_OK},
        '{8'hE0, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK},
        '{8'h80, 0, 0, 0, ST_OK}, '{8'h80, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK},
        '{8'hFF, 0, 0, 0, ST_OK}, '{8'hFF, 0, 0, 0, ST_OK}, '{8'hFF, 0, 0, 0, ST_OK},
        '{8'hFF, 0, 0, 0, ST_OK}, '{8'hFF, 0, 1, 1, ST_OVERRUN}
    };

    // Sender: reset, directed table, then random buffers with a little noise.
    initial begin
        pes_in_t it;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        parse_clear();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) begin
            it.data_byte = directed_rows[i].data_byte;
            it.first_byte = directed_rows[i].first_byte;
            it.last_byte = directed_rows[i].last_byte;
            send_request(it, directed_rows[i].has_status, directed_rows[i].status);
        end
        while (bytes_sent < 830) begin
            if ($urandom_range(0, 9) == 0) begin
                calm = 0;
                it.data_byte = rand_byte();
                it.first_byte = ($urandom_range(0, 3) == 0);
                it.last_byte = ($urandom_range(0, 3) == 0);
                send_request(it, 1'b0, ST_OK);
            end else begin
                send_buffer();
            end
        end
        release_sender();
        sending_done = 1;
    end

    // Receiver: random back-pressure, plus one long hold-off to fill the queue.
    initial begin
        int cycle_count;
        int stall;
        cycle_count = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            cycle_count++;
            if (cycle_count == 1500) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                cycle_count++;
            end
            stall = idle_cycles();
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            failures++;
        end
    endtask

    // Monitor: compare each taken result with the oldest expectation.
    always @(posedge aclk) begin
        pes_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, m_data.status);
                failures++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", m_data.status, want.status);
                check_field("stream_kind", m_data.stream_kind, want.stream_kind);
                check_field("packet_length", m_data.packet_length, want.packet_length);
                check_field("header_size", m_data.header_size, want.header_size);
                check_field("pts_value", m_data.pts_value, want.pts_value);
                check_field("dts_value", m_data.dts_value, want.dts_value);
                check_field("escr_value", m_data.escr_value, want.escr_value);
                check_field("es_rate_value", m_data.es_rate_value, want.es_rate_value);
                check_field("header_flag_bytes", m_data.header_flag_bytes,
                            want.header_flag_bytes);
                check_field("trick_mode_byte", m_data.trick_mode_byte, want.trick_mode_byte);
                check_field("previous_crc", m_data.previous_crc, want.previous_crc);
                check_field("extension_fields", m_data.extension_fields,
                            want.extension_fields);
            end
        end
    end

    // Finish: drain the expectations, let the pipeline settle, then report.
    initial begin
        wait (sending_done);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
